// ----- rtl/core/sbdd_pkg.sv -----
// Shared constants, control structs and state type for the binary to decimal digit unit.
`default_nettype none

package sbdd_pkg;

    localparam int VALUE_BITS_DEF = 128;
    localparam int MAX_DIGITS_DEF = 39;
    localparam int HALF_BITS      = 64;
    localparam int DIGIT_BITS     = 4;

    localparam logic SIGNED_MODE_RESET = 1'b1;

    localparam logic [DIGIT_BITS-1:0] DIGIT_ZERO   = 4'd0;
    localparam logic [DIGIT_BITS-1:0] DIGIT_FIVE   = 4'd5;
    localparam logic [DIGIT_BITS-1:0] DIGIT_ADJUST = 4'd3;
    localparam logic [DIGIT_BITS-1:0] DIGIT_NINE   = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LOAD,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } dab_ctrl_t;

    typedef struct packed {
        logic load;
        logic shift;
    } emit_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/sbdd_if.sv -----
// Request and result channel interfaces of the binary to decimal digit unit.
`default_nettype none

interface sbdd_in_if;
    logic                            valid;
    logic                            ready;
    logic [sbdd_pkg::HALF_BITS-1:0]  value_high;
    logic [sbdd_pkg::HALF_BITS-1:0]  value_low;

    modport source (output valid, output value_high, output value_low, input ready);
    modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

interface sbdd_out_if;
    logic                            valid;
    logic                            ready;
    logic [sbdd_pkg::DIGIT_BITS-1:0] digit;
    logic                            negative;
    logic                            last_digit;

    modport source (output valid, output digit, output negative, output last_digit,
                    input ready);
    modport sink   (input valid, input digit, input negative, input last_digit,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sbdd_dabble.sv -----
// Bit-serial double dabble: shifts the magnitude into a BCD register one bit per cycle while step is set.
`default_nettype none

module sbdd_dabble #(
    parameter int VALUE_BITS = sbdd_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = sbdd_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                     clk,
    input  wire sbdd_pkg::dab_ctrl_t                      ctrl,
    input  wire logic [VALUE_BITS-1:0]                    mag,
    output logic [sbdd_pkg::DIGIT_BITS*MAX_DIGITS-1:0]    bcd
);
    import sbdd_pkg::*;

    localparam int BCD_W = DIGIT_BITS * MAX_DIGITS;

    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_next;
    logic [BCD_W-1:0]      adj;

    always_comb
    begin
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            if (bcd_reg[DIGIT_BITS*k +: DIGIT_BITS] >= DIGIT_FIVE)
                adj[DIGIT_BITS*k +: DIGIT_BITS] = bcd_reg[DIGIT_BITS*k +: DIGIT_BITS]
                                                  + DIGIT_ADJUST;
            else
                adj[DIGIT_BITS*k +: DIGIT_BITS] = bcd_reg[DIGIT_BITS*k +: DIGIT_BITS];
        end
        // carry out of the top digit is dropped: result wraps mod 10^MAX_DIGITS
        bcd_next = {adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
        mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mag_reg <= mag;
            bcd_reg <= '0;
        end
        else if (ctrl.step)
        begin
            mag_reg <= mag_next;
            bcd_reg <= bcd_next;
        end
    end

    assign bcd = bcd_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sbdd_emit.sv -----
// Digit shifter: presents digits most significant first and flags a zero top digit so leading zeros can be dropped.
`default_nettype none

module sbdd_emit #(
    parameter int MAX_DIGITS = sbdd_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire sbdd_pkg::emit_ctrl_t                     ctrl,
    input  wire logic [sbdd_pkg::DIGIT_BITS*MAX_DIGITS-1:0] bcd,
    output logic [sbdd_pkg::DIGIT_BITS-1:0]               top_digit,
    output logic                                          top_zero,
    output logic                                          last
);
    import sbdd_pkg::*;

    localparam int BCD_W = DIGIT_BITS * MAX_DIGITS;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [BCD_W-1:0] dig_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            dig_reg <= bcd;
        else if (ctrl.shift)
            dig_reg <= {dig_reg[BCD_W-DIGIT_BITS-1:0], DIGIT_ZERO};
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.load)
            cnt_next = CNT_INIT;
        else if (ctrl.shift)
            cnt_next = cnt_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= CNT_INIT;
        else
            cnt_reg <= cnt_next;
    end

    assign top_digit = dig_reg[BCD_W-1 -: DIGIT_BITS];
    assign top_zero  = (top_digit == DIGIT_ZERO);
    assign last      = (cnt_reg == CNT_ONE);

endmodule

`default_nettype wire

// ----- rtl/core/signed_binary_to_decimal_digits_unit.sv -----
// Top level of the signed binary to decimal digit unit.
// Takes one VALUE_BITS-wide value per request (two 64-bit halves, upper bits
// ignored) and returns its decimal digits most significant first, one result
// each, no leading zeros, last digit flagged; zero gives a single 0. With
// signed mode set (reset default) a set top bit marks the value negative and
// its magnitude is converted. Magnitudes that need more than MAX_DIGITS digits
// wrap modulo 10^MAX_DIGITS. One request at a time: the next request can be
// accepted in the cycle after the last digit is accepted. Each request runs
// through the bit-serial double dabble shift of one bit per cycle, a load of
// the digit shifter, and a one-digit-per-cycle walk of the BCD register that
// either skips a leading zero or emits a digit; while a digit waits on an
// output stall, the walk holds.
// Write signed mode only while no request is in flight.
`default_nettype none

module signed_binary_to_decimal_digits_unit #(
    parameter int VALUE_BITS = sbdd_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = sbdd_pkg::MAX_DIGITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    sbdd_in_if.sink    operand,
    sbdd_out_if.source result
);
    import sbdd_pkg::*;

    localparam int BCD_W = DIGIT_BITS * MAX_DIGITS;
    localparam int BIT_W = $clog2(VALUE_BITS + 1);
    localparam logic [BIT_W-1:0] BIT_INIT = BIT_W'(VALUE_BITS);
    localparam logic [BIT_W-1:0] BIT_ONE  = BIT_W'(1);

    state_t               state_reg;
    state_t               state_next;
    logic                 signed_mode_reg;
    logic                 neg_reg;
    logic                 neg_next;
    logic [BIT_W-1:0]     bit_cnt_reg;
    logic [BIT_W-1:0]     bit_cnt_next;
    logic [2*HALF_BITS-1:0] raw_full;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic                 in_neg;
    logic                 in_fire;
    logic                 out_fire;
    dab_ctrl_t            dab_ctrl;
    emit_ctrl_t           emit_ctrl;
    logic [BCD_W-1:0]     bcd;
    logic [DIGIT_BITS-1:0] top_digit;
    logic                 top_zero;
    logic                 last;

    assign in_fire  = operand.valid && operand.ready;
    assign out_fire = result.valid && result.ready;

    assign raw_full = {operand.value_high, operand.value_low};
    assign raw      = raw_full[VALUE_BITS-1:0];
    assign in_neg   = signed_mode_reg && raw[VALUE_BITS-1];
    assign mag      = in_neg ? (~raw + VALUE_BITS'(1)) : raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            signed_mode_reg <= SIGNED_MODE_RESET;
        else if (cfg_we)
            signed_mode_reg <= cfg_wdata;
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        neg_next     = neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next   = ST_CONV;
                    bit_cnt_next = BIT_INIT;
                    neg_next     = in_neg;
                end
            end
            ST_CONV:
            begin
                bit_cnt_next = bit_cnt_reg - BIT_ONE;
                if (bit_cnt_reg == BIT_ONE)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
                state_next = ST_SKIP;
            ST_SKIP:
            begin
                if (!top_zero || last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_fire && last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        operand.ready   = 1'b0;
        result.valid    = 1'b0;
        dab_ctrl        = '0;
        emit_ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                operand.ready = 1'b1;
                dab_ctrl.load = in_fire;
            end
            ST_CONV:
                dab_ctrl.step = 1'b1;
            ST_LOAD:
                emit_ctrl.load = 1'b1;
            ST_SKIP:
                emit_ctrl.shift = top_zero && !last;
            ST_EMIT:
            begin
                result.valid    = 1'b1;
                emit_ctrl.shift = out_fire && !last;
            end
            default:
            begin
                operand.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            neg_reg     <= neg_next;
        end
    end

    sbdd_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .clk  (clk),
        .ctrl (dab_ctrl),
        .mag  (mag),
        .bcd  (bcd)
    );

    sbdd_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (emit_ctrl),
        .bcd       (bcd),
        .top_digit (top_digit),
        .top_zero  (top_zero),
        .last      (last)
    );

    assign result.digit      = top_digit;
    assign result.negative   = neg_reg;
    assign result.last_digit = last;

    a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.digit <= DIGIT_NINE))
        else $error("non-decimal digit on result");

    a_lead_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP && state_next == ST_EMIT && !last) |-> !top_zero)
        else $error("leading zero digit emitted");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_CONV && bit_cnt_reg == BIT_INIT))
        else $error("request did not start conversion");

    a_digits_continue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !result.last_digit) |=> result.valid)
        else $error("digit stream broken before last digit");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && result.last_digit) |=> (!result.valid && operand.ready))
        else $error("result still valid after last digit");

endmodule

`default_nettype wire
